// ===== rtl/core/csed_pkg.sv =====
// Shared types and constants for the CAN signal decoder.
package csed_pkg;
    typedef enum logic [1:0] {
        MODE_SIGNED   = 2'd0,
        MODE_UNSIGNED = 2'd1,
        MODE_FLOAT32  = 2'd2,
        MODE_DOUBLE   = 2'd3
    } t_mode;

    typedef enum logic {
        ORDER_MOTOROLA = 1'b0,
        ORDER_INTEL    = 1'b1
    } t_order;

    typedef struct packed {
        logic [63:0] frame_data;
        logic [3:0]  frame_length;
        logic [5:0]  start_bit;
        logic [6:0]  bit_length;
        logic        byte_order;
        logic [1:0]  mode;
    } t_desc;
endpackage

// ===== rtl/core/csed_if.sv =====
// Valid/ready channel interfaces for descriptor input and value output.
interface csed_in_if (input logic i_clk);
    import csed_pkg::*;
    logic  valid;
    logic  ready;
    t_desc payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface csed_out_if (input logic i_clk);
    logic        valid;
    logic        ready;
    logic [63:0] value_bits;
    modport source (output valid, output value_bits, input ready);
    modport sink   (input valid, input value_bits, output ready);
endinterface

// ===== rtl/core/can_signal_extract_to_double.sv =====
// Top level: CAN signal extraction and conversion to IEEE double bits.
// Input channel i_in carries one beat per signal: payload bytes, frame length,
// start bit, bit length, byte order and value type. Output channel o_out
// carries one beat with the decoded value as double bits.
// Pipeline: an input register, then the whole decode (byte reversal, shift,
// mask, sign handling, leading-one search, rounding, float widening) in one
// combinational pass into the result register. An accepted input beat is
// held in the input register, then moves into the result register when that
// is empty or being taken; throughput is one beat per cycle while the receiver
// takes beats.
// When the receiver stalls the result register holds, then the input stage
// holds; ready drops only when both stages are full and the receiver is not
// ready, so no beat is lost.
// Reset (synchronous, active low) empties both stages; no other state.
module can_signal_extract_to_double (
    input  logic i_clk,
    input  logic i_rst_n,
    csed_in_if.sink    i_in,
    csed_out_if.source o_out
);
    import csed_pkg::*;

    logic        r_in_vld, r_out_vld;
    t_desc       r_in;
    logic [63:0] r_val, n_val;
    logic        adv_out, adv_in;

    assign adv_out   = r_in_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready = !r_in_vld || adv_out;
    assign adv_in    = i_in.valid && i_in.ready;
    assign o_out.valid = r_out_vld;
    assign o_out.value_bits = r_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (adv_in) r_in_vld <= 1'b1;
            else if (adv_out) r_in_vld <= 1'b0;
            if (adv_out) r_out_vld <= 1'b1;
            else if (o_out.ready) r_out_vld <= 1'b0;
        end
        if (adv_in) r_in <= i_in.payload;
        if (adv_out) r_val <= n_val;
    end

    // integer to double, round to nearest even
    function automatic logic [63:0] u2d(input logic [63:0] x);
        logic [5:0]  p;
        logic [63:0] nx;
        logic [52:0] mant;
        logic [10:0] ex;
        logic        g, st;
        logic [53:0] rm;
        p = 6'd0;
        for (int k = 0; k < 64; k++) if (x[k]) p = 6'(k);
        nx = x << (6'd63 - p);
        ex = 11'(1023) + {5'd0, p};
        mant = nx[63:11];
        g  = nx[10];
        st = |nx[9:0];
        rm = {1'b0, mant} + {53'd0, g && (st || mant[0])};
        if (rm[53]) begin
            ex = ex + 11'd1;
            rm = rm >> 1;
        end
        u2d = (x == 64'd0) ? 64'd0 : {1'b0, ex, rm[51:0]};
    endfunction

    function automatic logic [63:0] f2d(input logic [31:0] b);
        logic [7:0]  e;
        logic [22:0] m;
        logic [4:0]  q;
        logic [51:0] mm;
        e = b[30:23];
        m = b[22:0];
        q = 5'd0;
        for (int k = 0; k < 23; k++) if (m[k]) q = 5'(k);
        mm = {29'd0, m} << (6'd52 - {1'b0, q});
        if (e == 8'hFF)
            f2d = (m != 0) ? 64'd0 : {b[31], 11'h7FF, 52'd0};
        else if (e == 8'd0)
            f2d = (m == 0) ? {b[31], 63'd0}
                           : {b[31], 11'(874) + {6'd0, q}, mm};
        else
            f2d = {b[31], {3'd0, e} + 11'(896), m, 29'd0};
    endfunction

    always_comb begin
        logic [3:0]  len;
        logic [6:0]  w;
        logic [63:0] data, rev, field, mask;
        logic signed [9:0] pos;
        logic [2:0]  sb_lo;
        len  = (r_in.frame_length > 4'd8) ? 4'd8 : r_in.frame_length;
        w    = (r_in.bit_length > 7'd64) ? 7'd64 : r_in.bit_length;
        for (int k = 0; k < 8; k++)
            data[8*k +: 8] = (4'(k) < len) ? r_in.frame_data[8*k +: 8] : 8'd0;
        rev = 64'd0;
        for (int k = 0; k < 8; k++)
            for (int j = 0; j < 8; j++)
                if (4'(j) < len && 4'(k + j) == len - 4'd1)
                    rev[8*k +: 8] = data[8*j +: 8];
        sb_lo = r_in.start_bit[2:0] + 3'd1;
        if (r_in.byte_order == ORDER_MOTOROLA) begin
            pos = $signed({3'd0, len, 3'd0}) - $signed({4'd0, r_in.start_bit[5:3], 3'd0})
                - $signed({7'd0, 3'd0 - sb_lo}) - $signed({3'd0, w});
            data = rev;
        end else
            pos = $signed({4'd0, r_in.start_bit});
        if (pos >= 10'sd64 || pos <= -10'sd64) field = 64'd0;
        else if (pos >= 0) field = data >> pos[5:0];
        else field = data << 6'(-pos);
        mask = (w[6]) ? '1 : ((64'd1 << w[5:0]) - 64'd1);
        field = field & mask;
        case (t_mode'(r_in.mode))
            MODE_SIGNED:
                if (w == 7'd0) n_val = 64'd0;
                else if (field[6'(w - 7'd1)])
                    n_val = {1'b1, 63'd0} | u2d(64'd0 - (field | ~mask));
                else n_val = u2d(field);
            MODE_UNSIGNED: n_val = u2d(field);
            MODE_FLOAT32:  n_val = f2d(field[31:0]);
            default:       n_val = field;
        endcase
    end
endmodule

// ===== sim/tb_top.sv =====
// Testbench for the CAN signal decoder: random and directed descriptors, scoreboard check.
module tb_top;
    import csed_pkg::*;

    logic i_clk;
    logic i_rst_n;

    csed_in_if  in_ch (i_clk);
    csed_out_if out_ch (i_clk);

    can_signal_extract_to_double dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    // int -> double bits, round to nearest even
    function automatic logic [63:0] int_to_dbl(input logic [63:0] x);
        int p;
        int sh;
        logic [63:0] mant;
        logic [63:0] rem;
        logic [63:0] half;
        logic [10:0] ex;
        if (x == 0) return 64'd0;
        p = 63;
        while (x[p] == 1'b0) p--;
        ex = 11'(1023 + p);
        if (p <= 52) begin
            mant = x << (52 - p);
        end else begin
            sh = p - 52;
            rem = x & ((64'd1 << sh) - 64'd1);
            half = 64'd1 << (sh - 1);
            mant = x >> sh;
            if (rem > half || (rem == half && mant[0])) mant++;
            if (mant == (64'd1 << 53)) begin
                mant = mant >> 1;
                ex++;
            end
        end
        return {1'b0, ex, mant[51:0]};
    endfunction

    function automatic logic [63:0] f32_to_dbl(input logic [31:0] b);
        logic [7:0] e;
        logic [22:0] m;
        int q;
        e = b[30:23];
        m = b[22:0];
        if (e == 8'hFF) return (m != 0) ? 64'd0 : {b[31], 11'h7FF, 52'd0};
        if (e == 0) begin
            if (m == 0) return {b[31], 63'd0};
            q = 22;
            while (m[q] == 1'b0) q--;
            return {b[31], 11'(1023 + q - 149), 52'({29'd0, m} << (52 - q))};
        end
        return {b[31], 11'(e - 127 + 1023), m, 29'd0};
    endfunction

    function automatic logic [63:0] decode_signal(input t_desc d);
        logic [63:0] data;
        logic [63:0] rev;
        logic [63:0] field;
        logic [63:0] mask;
        int len;
        int width;
        int sb;
        int pos;
        len = (d.frame_length > 8) ? 8 : int'(d.frame_length);
        width = (d.bit_length > 64) ? 64 : int'(d.bit_length);
        sb = int'(d.start_bit);
        data = d.frame_data;
        if (len < 8) data &= (64'd1 << (8 * len)) - 64'd1;
        if (t_order'(d.byte_order) == ORDER_MOTOROLA) begin
            rev = 0;
            for (int i = 0; i < len; i++)
                rev |= ((data >> (8 * i)) & 64'hFF) << (8 * (len - 1 - i));
            data = rev;
            pos = 8 * len - 8 * (sb / 8) - ((8 - ((sb + 1) % 8)) % 8) - width;
        end else begin
            pos = sb;
        end
        if (pos >= 64 || pos <= -64) field = 0;
        else if (pos >= 0) field = data >> pos;
        else field = data << (-pos);
        mask = (width >= 64) ? '1 : ((64'd1 << width) - 64'd1);
        field &= mask;
        case (t_mode'(d.mode))
            MODE_SIGNED: begin
                if (width == 0) return 64'd0;
                if (field[width - 1]) return {1'b1, 63'd0} | int_to_dbl(64'd0 - (field | ~mask));
                return int_to_dbl(field);
            end
            MODE_UNSIGNED: return int_to_dbl(field);
            MODE_FLOAT32: return f32_to_dbl(field[31:0]);
            default: return field;
        endcase
    endfunction

    class value_scoreboard;
        logic [63:0] pending[$];
        int errors;
        function void note_desc(t_desc d);
            pending.push_back(decode_signal(d));
        endfunction
        function void check_value(logic [63:0] got);
            logic [63:0] want;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected beat value_bits=%h", got);
                return;
            end
            want = pending.pop_front();
            if (want !== got) begin
                errors++;
                if (errors <= 10) $display("value_bits mismatch exp=%h got=%h", want, got);
            end
        endfunction
    endclass

    value_scoreboard sb = new();
    bit quiet_tail;
    int hold_cycles;
    int sent;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // input/output monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) sb.note_desc(in_ch.payload);
            if (out_ch.valid && out_ch.ready) sb.check_value(out_ch.value_bits);
        end
    end

    // receiver: random stall bursts, one long hold
    initial begin
        int n;
        out_ch.ready = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                out_ch.ready <= 0;
                hold_cycles--;
            end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 5);
                out_ch.ready <= 0;
                repeat (n - 1) @(negedge i_clk);
            end else begin
                out_ch.ready <= 1;
            end
        end
    end

    function automatic t_desc rand_desc(input bit wellformed);
        t_desc d;
        int len;
        d.frame_data = {$urandom, $urandom};
        d.frame_length = 4'($urandom_range(0, 15));
        d.start_bit = 6'($urandom);
        d.bit_length = 7'($urandom);
        d.byte_order = 1'($urandom);
        d.mode = 2'($urandom);
        if (wellformed) begin
            len = $urandom_range(1, 8);
            d.frame_length = 4'(len);
            if (len < 8) d.frame_data &= (64'd1 << (8 * len)) - 64'd1;
            case (t_mode'(d.mode))
                MODE_FLOAT32: d.bit_length = 7'd32;
                MODE_DOUBLE: d.bit_length = 7'd64;
                default: d.bit_length = 7'($urandom_range(1, 8 * len));
            endcase
            if (d.byte_order == ORDER_INTEL)
                d.start_bit = 6'($urandom_range(0, 8 * len - int'(d.bit_length)));
            else
                d.start_bit = 6'($urandom_range(0, 8 * len - 1));
        end
        return d;
    endfunction

    task automatic send_desc(input t_desc d, input bit gaps);
        if (gaps && $urandom_range(0, 5) == 0) begin
            in_ch.valid <= 0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
        in_ch.valid <= 1;
        in_ch.payload <= d;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        sent++;
    endtask

    task automatic directed_set();
        t_desc d;
        t_mode m;
        m = m.first();
        for (int k = 0; k < 4; k++) begin
            d = '{64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 6'd0, 7'd64, 1'b1, m};
            send_desc(d, 0);
            d = '{64'h8000_0000_0000_0001, 4'd8, 6'd63, 7'd64, 1'b0, m};
            send_desc(d, 0);
            m = m.next();
        end
        send_desc('{64'h0, 4'd0, 6'd0, 7'd0, 1'b1, MODE_SIGNED}, 0);
        send_desc('{64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 6'd7, 7'd127, 1'b0, MODE_UNSIGNED}, 0);
        send_desc('{64'hAAAA_5555_1234_5678, 4'd3, 6'd5, 7'd16, 1'b1, MODE_UNSIGNED}, 0);
        send_desc('{64'h0, 4'd8, 6'd0, 7'd32, 1'b1, MODE_FLOAT32}, 0);
        send_desc('{64'h7FC0_0001, 4'd8, 6'd0, 7'd32, 1'b1, MODE_FLOAT32}, 0);
        send_desc('{64'h7F80_0000, 4'd8, 6'd0, 7'd32, 1'b1, MODE_FLOAT32}, 0);
        send_desc('{64'hFF80_0000, 4'd8, 6'd0, 7'd32, 1'b1, MODE_FLOAT32}, 0);
        send_desc('{64'h8000_0001, 4'd8, 6'd0, 7'd32, 1'b1, MODE_FLOAT32}, 0);
        send_desc('{64'h0012_3456, 4'd8, 6'd0, 7'd20, 1'b1, MODE_FLOAT32}, 0);
        send_desc('{64'h0000_0000_0000_00FF, 4'd1, 6'd63, 7'd64, 1'b0, MODE_SIGNED}, 0);
        send_desc('{64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 6'd0, 7'd40, 1'b1, MODE_DOUBLE}, 0);
        // rounding: a 2^53+1 tie case and a 2^54+2^53+3 round-up case
        send_desc('{64'h0020_0000_0000_0001, 4'd8, 6'd0, 7'd64, 1'b1, MODE_UNSIGNED}, 0);
        send_desc('{64'h0060_0000_0000_0003, 4'd8, 6'd0, 7'd64, 1'b1, MODE_UNSIGNED}, 0);
        send_desc('{64'h8000_0000_0000_0000, 4'd8, 6'd0, 7'd64, 1'b1, MODE_SIGNED}, 0);
        send_desc('{64'h00FF_FFFF_FFFF_FFFF, 4'd8, 6'd0, 7'd64, 1'b1, MODE_UNSIGNED}, 0);
    endtask

    initial begin
        t_desc d;
        i_rst_n = 0;
        in_ch.valid = 0;
        in_ch.payload = '0;
        hold_cycles = 0;
        quiet_tail = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;
        directed_set();
        // sender pauses until every result is back
        in_ch.valid <= 0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        hold_cycles = 40;
        for (int k = 0; k < 500; k++) begin
            if (k == 450) quiet_tail = 1;
            d = rand_desc($urandom_range(0, 3) != 0);
            send_desc(d, !quiet_tail);
        end
        in_ch.valid <= 0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        if (sb.errors == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end

    initial begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end
endmodule
